>>> src/satl_pkg.sv
`default_nettype none
package satl_pkg;

  localparam int LFSR_W = 16;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
  localparam int STAMP_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFS_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd3;

  localparam logic [1:0] MODE_LRU = 2'd0;
  localparam logic [1:0] MODE_MRU = 2'd1;
  localparam logic [1:0] MODE_RAND = 2'd2;

  localparam logic [1:0] ST_HIT = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_REPLACE = 2'd2;

  typedef struct packed {
    logic [31:0] address;
    logic        write_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] replaced_address;
    logic        victim_dirty;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic div_start;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic need_div;
    logic div_done;
    logic slot_free;
  } dp_status_t;

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] n;
    n = v >> 1;
    if (v[0]) begin
      n = n ^ LFSR_TAPS;
    end
    return n;
  endfunction

endpackage
`default_nettype wire

>>> src/set_assoc_cache_tag_lookup_unit.sv
// The result is registered on commit, after the set row has been read from the RAM; commit
// waits while the result register is full, and pseudo-random replacement also waits for
// the serial remainder unit. A new item is accepted only after the previous one is committed,
// bound by the read-modify-write of one set row in the RAM.
// Reset: synchronous, active low; configuration returns to 6/4/8/LRU, counter 0, LFSR 1.
// After reset a clearing pass writes every set row before in_ready is raised.
`default_nettype none
module set_assoc_cache_tag_lookup_unit
  import satl_pkg::*;
#(
  parameter int MAX_SET_BITS = 6,
  parameter int NUM_WAYS = 8,
  parameter int ADDR_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t st;

  satl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .st      (st),
    .cmd     (cmd)
  );

  satl_dp #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .NUM_WAYS    (NUM_WAYS),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .st       (st),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

endmodule
`default_nettype wire

>>> src/satl_ram.sv
`default_nettype none
module satl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/satl_mod.sv
`default_nettype none
module satl_mod
  import satl_pkg::*;
#(
  parameter int VW = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [LFSR_W-1:0] dividend,
  input  wire logic [VW-1:0]     divisor,
  output logic                   done,
  output logic [VW-1:0]          rem
);

  localparam int CW = $clog2(LFSR_W + 1);

  logic [LFSR_W-1:0] q_r, q_nxt;
  logic [VW-1:0]     rem_r, rem_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [VW:0]       trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    trial = {rem_r, q_r[LFSR_W-1]};
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      // one quotient bit per cycle, restoring
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
      end
      rem_nxt = trial[VW-1:0];
      q_nxt = q_r << 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(LFSR_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem = rem_r;

endmodule
`default_nettype wire

>>> src/satl_ctrl.sv
`default_nettype none
module satl_ctrl
  import satl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t st,
  output dp_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LOOK  = 4'b0100,
    S_DIV   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (st.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end else if (st.slot_free) begin
          cmd.commit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (st.div_done && st.slot_free) begin
          cmd.commit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/satl_dp.sv
`default_nettype none
module satl_dp
  import satl_pkg::*;
#(
  parameter int MAX_SET_BITS = 6,
  parameter int NUM_WAYS = 8,
  parameter int ADDR_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dp_cmd_t               cmd,
  output dp_status_t                 st,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = ADDR_WIDTH > 32 ? 32 : ADDR_WIDTH;
  localparam logic [31:0] AMASK = 32'((64'd1 << AW) - 64'd1);
  localparam int SETS = 1 << MAX_SET_BITS;
  localparam int SW = MAX_SET_BITS > 0 ? MAX_SET_BITS : 1;
  localparam int WAYW = $clog2(NUM_WAYS + 1);
  localparam int WIDX = NUM_WAYS > 1 ? $clog2(NUM_WAYS) : 1;
  localparam int WW = 2 + AW + STAMP_W;
  localparam int ROW_W = WW * NUM_WAYS;
  localparam int TAG_LO = STAMP_W;
  localparam int DIRTY_B = STAMP_W + AW;
  localparam int VALID_B = STAMP_W + AW + 1;

  // configuration
  logic [2:0] set_bits_r;
  logic [4:0] ofs_bits_r;
  logic [3:0] ways_r;
  logic [1:0] mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r <= 3'd6;
      ofs_bits_r <= 5'd4;
      ways_r <= 4'd8;
      mode_r <= MODE_LRU;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SET_BITS: set_bits_r <= cfg_wdata[2:0];
        CFG_OFS_BITS: ofs_bits_r <= cfg_wdata;
        CFG_WAYS:     ways_r <= cfg_wdata[3:0];
        CFG_MODE:     mode_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  logic [3:0]      s_eff;
  logic [WAYW-1:0] weff;
  logic [4:0]      ways5;

  always_comb begin
    s_eff = (int'(set_bits_r) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : {1'b0, set_bits_r};
    ways5 = {1'b0, ways_r};
    if (ways5 == 5'd0) begin
      weff = WAYW'(1);
    end else if (int'(ways5) > NUM_WAYS) begin
      weff = WAYW'(NUM_WAYS);
    end else begin
      weff = WAYW'(ways5);
    end
  end

  // address split at accept
  logic [31:0]   addr_m, blk, set_full, tag_full;
  logic [SW-1:0] set_in, set_r;
  logic [AW-1:0] tag_r;
  logic          wr_r;

  always_comb begin
    addr_m = in_data.address & AMASK;
    blk = addr_m >> ofs_bits_r;
    set_full = blk & ((32'd1 << s_eff) - 32'd1);
    tag_full = blk >> s_eff;
    set_in = SW'(set_full);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      set_r <= set_in;
      tag_r <= AW'(tag_full);
      wr_r <= in_data.write_req;
    end
  end

  // access counter and lfsr
  logic [STAMP_W-1:0] cnt_r;
  logic [LFSR_W-1:0]  lfsr_r;
  logic               use_rand;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      lfsr_r <= LFSR_SEED;
    end else begin
      if (cmd.accept && cnt_r != '1) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.commit && use_rand) begin
        lfsr_r <= lfsr_next(lfsr_r);
      end
    end
  end

  // clearing sweep
  logic [SW-1:0] clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  // set store
  logic [ROW_W-1:0] row_rd, row_wr;
  logic             ram_we;
  logic [SW-1:0]    ram_wa;
  logic [ROW_W-1:0] ram_wd;

  assign ram_we = cmd.clear | cmd.commit;
  assign ram_wa = cmd.clear ? clr_r : set_r;
  assign ram_wd = cmd.clear ? '0 : row_wr;

  satl_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_wa),
    .wdata(ram_wd),
    .re   (cmd.accept),
    .raddr(set_in),
    .rdata(row_rd)
  );

  // random victim remainder
  logic             div_done;
  logic [WAYW-1:0]  div_rem;

  satl_mod #(.VW(WAYW)) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend(lfsr_next(lfsr_r)),
    .divisor (weff),
    .done    (div_done),
    .rem     (div_rem)
  );

  // way compare and victim select
  logic               hit, empty;
  logic [WIDX-1:0]    hit_w, emp_w, best_w, vic_w, sel_w;
  logic [STAMP_W-1:0] best;
  logic [WW-1:0]      way, vic_way;
  logic [31:0]        vic_tag;
  logic [63:0]        ra;

  always_comb begin
    hit = 1'b0;
    empty = 1'b0;
    hit_w = '0;
    emp_w = '0;
    best_w = '0;
    best = row_rd[STAMP_W-1:0];
    for (int w = 0; w < NUM_WAYS; w++) begin
      way = row_rd[w*WW +: WW];
      if (w < int'(weff)) begin
        if (!hit && way[VALID_B] && way[TAG_LO +: AW] == tag_r) begin
          hit = 1'b1;
          hit_w = WIDX'(w);
        end
        if (!empty && !way[VALID_B]) begin
          empty = 1'b1;
          emp_w = WIDX'(w);
        end
        if ((mode_r == MODE_LRU && way[STAMP_W-1:0] < best) ||
            (mode_r == MODE_MRU && way[STAMP_W-1:0] > best)) begin
          best = way[STAMP_W-1:0];
          best_w = WIDX'(w);
        end
      end
    end
  end

  assign use_rand = !hit && !empty && mode_r == MODE_RAND;

  always_comb begin
    if (use_rand) begin
      vic_w = WIDX'(div_rem);
    end else if (mode_r == MODE_LRU || mode_r == MODE_MRU) begin
      vic_w = best_w;
    end else begin
      vic_w = '0;
    end
    priority if (hit) begin
      sel_w = hit_w;
    end else if (empty) begin
      sel_w = emp_w;
    end else begin
      sel_w = vic_w;
    end
    vic_way = row_rd[WW-1:0];
    row_wr = row_rd;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (WIDX'(w) == vic_w) begin
        vic_way = row_rd[w*WW +: WW];
      end
      if (WIDX'(w) == sel_w) begin
        if (hit) begin
          row_wr[w*WW + DIRTY_B] = row_rd[w*WW + DIRTY_B] | wr_r;
          row_wr[w*WW +: STAMP_W] = cnt_r;
        end else begin
          row_wr[w*WW +: WW] = {1'b1, wr_r, tag_r, cnt_r};
        end
      end
    end
    vic_tag = 32'(vic_way[TAG_LO +: AW]);
    ra = ({32'd0, vic_tag} << (6'(s_eff) + 6'(ofs_bits_r))) |
         ({{(64-SW){1'b0}}, set_r} << ofs_bits_r);
  end

  // result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  always_comb begin
    out_nxt = out_r;
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
      out_nxt = '0;
      priority if (hit) begin
        out_nxt.status = ST_HIT;
      end else if (empty) begin
        out_nxt.status = ST_FILL;
      end else begin
        out_nxt.status = ST_REPLACE;
        out_nxt.replaced_address = ra[31:0] & AMASK;
        out_nxt.victim_dirty = vic_way[DIRTY_B];
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  assign st.clear_last = (clr_r == SW'(SETS - 1));
  assign st.need_div = use_rand;
  assign st.div_done = div_done;
  assign st.slot_free = !out_valid_r || out_ready;

endmodule
`default_nettype wire
